@@ sv/kab_pkg.sv @@
`default_nettype none
package kab_pkg;

  typedef logic signed [71:0] wide_t;

  localparam int unsigned NumRegs = 3;
  localparam logic [30:0] QAngleReset = 31'd16777;
  localparam logic [30:0] QBiasReset  = 31'd50332;
  localparam logic [30:0] RNoiseReset = 31'd503316;

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_NOISE = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_OUT  = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  typedef struct packed {
    logic               start;
    logic [31:0]        divisor;
    logic signed [31:0] num0;
    logic signed [31:0] num1;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo0;
    logic signed [31:0] quo1;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input wide_t x);
    logic signed [31:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic wide_t rs16(input wide_t x);
    return (x + 72'sd32768) >>> 16;
  endfunction

  function automatic wide_t rs24(input wide_t x);
    return (x + 72'sd8388608) >>> 24;
  endfunction

endpackage
`default_nettype wire

@@ sv/kab_ifs.sv @@
`default_nettype none
interface kab_sample_if (input wire logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic [15:0]        elapsed_time;
  logic               force_angle;
  modport source (output valid, measured_angle, gyro_rate, elapsed_time, force_angle,
                  input ready);
  modport sink (input valid, measured_angle, gyro_rate, elapsed_time, force_angle,
                output ready);
endinterface

interface kab_result_if (input wire logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] bias_estimate;
  modport source (output valid, filtered_angle, bias_estimate, input ready);
  modport sink (input valid, filtered_angle, bias_estimate, output ready);
endinterface

interface kab_cfg_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/kab_div.sv @@
`default_nettype none
module kab_div
  import kab_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] divisor;
  logic        neg0, neg1;
  logic [31:0] rem0, rem1;
  logic [55:0] n0, n1;
  logic [32:0] trial0, trial1;
  logic        ge0, ge1;
  logic [55:0] q0_next, q1_next;

  function automatic logic [31:0] magnitude(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] signed_sat(input logic [55:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (q > 56'd2147483648) ? 32'sh80000000 : 32'(~q + 56'd1);
    end else begin
      r = (q > 56'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
    end
    return r;
  endfunction

  assign trial0 = {rem0, n0[55]};
  assign trial1 = {rem1, n1[55]};
  assign ge0 = trial0 >= {1'b0, divisor};
  assign ge1 = trial1 >= {1'b0, divisor};
  assign q0_next = {n0[54:0], ge0};
  assign q1_next = {n1[54:0], ge1};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy && !req.start && (cnt == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd55;
        divisor <= req.divisor;
        neg0 <= req.num0[31];
        neg1 <= req.num1[31];
        rem0 <= '0;
        rem1 <= '0;
        n0 <= {magnitude(req.num0), 24'd0};
        n1 <= {magnitude(req.num1), 24'd0};
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        rem0 <= ge0 ? 32'(trial0 - {1'b0, divisor}) : trial0[31:0];
        rem1 <= ge1 ? 32'(trial1 - {1'b0, divisor}) : trial1[31:0];
        n0 <= q0_next;
        n1 <= q1_next;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          rsp.quo0 <= signed_sat(q0_next, neg0);
          rsp.quo1 <= signed_sat(q1_next, neg1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/kalman_angle_bias_filter_top.sv @@
`default_nettype none
// Channel  Direction  Payload
// sample   in         measured_angle, gyro_rate, elapsed_time, force_angle
// result   out        filtered_angle, bias_estimate
// cfg      in         index, data (register write)
// A filtered sample runs ten multiplies on one shared multiplier, each a
// multiply and an accumulate state, with a 56-step bit-serial divider
// that forms both gains side by side between the fourth and fifth, then
// the output and idle states. Without a positive innovation variance the
// divider is skipped and both gains are zero. Forced samples go to output.
// Reset is synchronous; it clears the estimates and the covariance and loads
// the noise registers with their defaults. A stalled result is held in the
// output register while the next sample is already taken in.
module kalman_angle_bias_filter_top
  import kab_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  kab_sample_if.sink   sample,
  kab_result_if.source result,
  kab_cfg_if.sink      cfg
);

  typedef enum logic [3:0] {
    OP_RATE   = 4'd0,
    OP_DTP11  = 4'd1,
    OP_P00    = 4'd2,
    OP_P11    = 4'd3,
    OP_ANGLE  = 4'd4,
    OP_BIAS   = 4'd5,
    OP_P10    = 4'd6,
    OP_P00U   = 4'd7,
    OP_P11U   = 4'd8,
    OP_P01U   = 4'd9
  } op_t;

  state_t state;
  op_t    op;
  logic [30:0] q_angle, q_bias, r_noise;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, gyro;
  logic [15:0]        dt;
  logic signed [33:0] dtp11;
  logic signed [31:0] k0, k1, y;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  wide_t              prod;
  logic signed [35:0] t_term;
  logic signed [33:0] s_sum;
  logic               s_pos;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               accept;
  logic               out_load;

  assign accept = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_load = ((state == S_OUT) || (state == S_WAIT)) &&
                    (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= QAngleReset;
      q_bias <= QBiasReset;
      r_noise <= RNoiseReset;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_Q_ANGLE: q_angle <= cfg.data[30:0];
        REG_Q_BIAS:  q_bias <= cfg.data[30:0];
        REG_R_NOISE: r_noise <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  assign t_term = 36'(dtp11) - 36'(p01) - 36'(p10) + $signed({5'd0, q_angle});
  assign s_sum = 34'(p00) + $signed({3'd0, r_noise});
  assign s_pos = !s_sum[33] && (s_sum != '0);

  always_comb begin
    mul_a = '0;
    mul_b = $signed({17'd0, dt});
    case (op)
      OP_RATE:  mul_a = 36'(33'(gyro) - 33'(bias));
      OP_DTP11: mul_a = 36'(p11);
      OP_P00:   mul_a = t_term;
      OP_P11:   mul_a = $signed({5'd0, q_bias});
      OP_ANGLE: begin mul_a = 36'(k0); mul_b = 33'(y); end
      OP_BIAS:  begin mul_a = 36'(k1); mul_b = 33'(y); end
      OP_P10:   begin mul_a = 36'(k1); mul_b = 33'(p00); end
      OP_P00U:  begin mul_a = 36'(k0); mul_b = 33'(p00); end
      OP_P11U:  begin mul_a = 36'(k1); mul_b = 33'(p01); end
      OP_P01U:  begin mul_a = 36'(k0); mul_b = 33'(p01); end
      default: ;
    endcase
  end

  assign dreq.start = (state == S_ACC) && (op == OP_P11) && s_pos;
  assign dreq.divisor = s_sum[31:0];
  assign dreq.num0 = p00;
  assign dreq.num1 = p10;

  kab_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_RATE;
      ang <= '0;
      bias <= '0;
      p00 <= '0;
      p01 <= '0;
      p10 <= '0;
      p11 <= '0;
      result.valid <= 1'b0;
    end else begin
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            meas <= sample.measured_angle;
            gyro <= sample.gyro_rate;
            dt <= sample.elapsed_time;
            op <= OP_RATE;
            if (sample.force_angle) begin
              ang <= sample.measured_angle;
              state <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod <= 72'(mul_a * mul_b);
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_MUL;
          op <= op_t'(op + 4'd1);
          case (op)
            OP_RATE:  ang <= sat32(wide_t'(ang) + rs16(prod));
            OP_DTP11: dtp11 <= 34'(rs16(prod));
            OP_P00: begin
              p00 <= sat32(wide_t'(p00) + rs16(prod));
              p01 <= sat32(wide_t'(p01) - wide_t'(dtp11));
              p10 <= sat32(wide_t'(p10) - wide_t'(dtp11));
            end
            OP_P11: begin
              p11 <= sat32(wide_t'(p11) + rs16(prod));
              y <= sat32(wide_t'(meas) - wide_t'(ang));
              if (s_pos) begin
                state <= S_DIV;
              end else begin
                k0 <= '0;
                k1 <= '0;
              end
            end
            OP_ANGLE: ang <= sat32(wide_t'(ang) + rs24(prod));
            OP_BIAS:  bias <= sat32(wide_t'(bias) + rs24(prod));
            OP_P10:   p10 <= sat32(wide_t'(p10) - rs24(prod));
            OP_P00U:  p00 <= sat32(wide_t'(p00) - rs24(prod));
            OP_P11U:  p11 <= sat32(wide_t'(p11) - rs24(prod));
            OP_P01U: begin
              p01 <= sat32(wide_t'(p01) - rs24(prod));
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            k0 <= drsp.quo0;
            k1 <= drsp.quo1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_load) begin
            result.filtered_angle <= ang;
            result.bias_estimate <= bias;
            state <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            result.filtered_angle <= ang;
            result.bias_estimate <= bias;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_force_short: assert property (@(posedge clk) disable iff (rst)
    accept && sample.force_angle |=> state == S_OUT)
    else $error("forced sample did not go straight to output");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready)
    else $error("sample taken while a sample is in progress");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_OUT || state == S_WAIT))
    else $error("result raised outside the output phase");

endmodule
`default_nettype wire
